// File: rtl/core/h2r_pkg.sv
`timescale 1ns / 1ps

package h2r_pkg;

  // Field widths of the item on each side.
  localparam int HUE_W  = 16;
  localparam int FRAC_W = 13;
  localparam int CH_W   = 8;

  // Fixed-point scales: 4096 is 1.0 for fractions, 3840 hue units make 60 degrees.
  localparam int UNIT_ONE     = 4096;
  localparam int SECTOR_UNITS = 3840;
  localparam int HUE_PERIOD   = 2 * SECTOR_UNITS;
  localparam int HUE_WRAPS    = (2 ** HUE_W - 1) / HUE_PERIOD;
  localparam int WRAP_W       = $clog2(HUE_WRAPS + 1);

  // Internal widths of the datapath.
  localparam int A_W  = 14;  // 1 - |2L - 1|, signed
  localparam int AS_W = 28;  // chroma, signed
  localparam int HM_W = 13;  // hue modulo two sectors
  localparam int B_W  = 12;  // 1 - |h mod 2 - 1|, 0..3840
  localparam int D_W  = 30;  // 2L - chroma, signed
  localparam int N_W  = 42;  // channel numerator, signed
  localparam int T_W  = 51;  // scaled and biased numerator, signed

  // Final scaling: channel = floor(t / (15 * 2^32)), saturated at 255.
  localparam int          Q_SHIFT    = 32;
  localparam longint      ROUND_BIAS = 64'sd15 * (64'sd1 <<< 31);
  localparam int          SAT_LIMIT  = 256 * 15;
  localparam int          RECIP_15   = 4369;
  localparam int          U_W        = T_W - 1 - Q_SHIFT;
  localparam int          UQ_W       = 12;

  // Hue sectors, 60 degrees each; everything from 300 degrees up is the last.
  localparam logic [2:0] SEC_RED_YELLOW   = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN   = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE    = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED  = 3'd5;

  typedef logic signed [N_W-1:0] num_t;
  typedef logic signed [T_W-1:0] tnum_t;

endpackage

// File: rtl/core/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                         Item
// in_      slave      in_tvalid/in_tready/in_tdata  hue, saturation, lightness
// out_     master     out_tvalid/out_tready/out_tdata  red, green, blue
//
// One item per clock cycle is taken while the pipeline is not stalled by out_tready.
// Each item passes the seven register stages, cut around the two wide multipliers,
// the wide adds and the reciprocal divide by 15 in the last stage.
// Reset (rst_n low, synchronous) empties every stage; no result is pending after it.
// A stall on out_tready holds each full stage; empty stages still fill, so bubbles close up.
module hsl_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] hue, [28:16] saturation, [41:29] lightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  localparam int HUE_W  = h2r_pkg::HUE_W;
  localparam int FRAC_W = h2r_pkg::FRAC_W;
  localparam int CH_W   = h2r_pkg::CH_W;
  localparam int A_W    = h2r_pkg::A_W;
  localparam int AS_W   = h2r_pkg::AS_W;
  localparam int HM_W   = h2r_pkg::HM_W;
  localparam int B_W    = h2r_pkg::B_W;
  localparam int D_W    = h2r_pkg::D_W;
  localparam int N_W    = h2r_pkg::N_W;
  localparam int T_W    = h2r_pkg::T_W;
  localparam int U_W    = h2r_pkg::U_W;
  localparam int UQ_W   = h2r_pkg::UQ_W;
  localparam int WRAP_W = h2r_pkg::WRAP_W;

  // Unpack the input item.
  logic [HUE_W-1:0]  in_hue;
  logic [FRAC_W-1:0] in_sat;
  logic [FRAC_W-1:0] in_lig;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W+FRAC_W-1:HUE_W];
  assign in_lig = in_tdata[HUE_W+2*FRAC_W-1:HUE_W+FRAC_W];

  // Stage valid bits and the ready chain from the output back to the input.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, out_rdy;

  assign out_rdy   = !out_v_r || out_tready;
  assign s6_rdy    = !s6_v_r  || out_rdy;
  assign s5_rdy    = !s5_v_r  || s6_rdy;
  assign s4_rdy    = !s4_v_r  || s5_rdy;
  assign s3_rdy    = !s3_v_r  || s4_rdy;
  assign s2_rdy    = !s2_v_r  || s3_rdy;
  assign s1_rdy    = !s1_v_r  || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= in_tvalid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (s4_rdy)  s4_v_r  <= s3_v_r;
      if (s5_rdy)  s5_v_r  <= s4_v_r;
      if (s6_rdy)  s6_v_r  <= s5_v_r;
      if (out_rdy) out_v_r <= s6_v_r;
    end
  end

  // Stage 1: 1 - |2L - 1|, hue sector and the number of whole 120-degree wraps.
  logic signed [A_W:0]   dl_nxt;
  logic [A_W-1:0]        dl_abs;
  logic signed [A_W:0]   a_full;
  logic [2:0]            sec_nxt;
  logic [WRAP_W-1:0]     wrap_nxt;

  always_comb begin
    dl_nxt = $signed({1'b0, in_lig, 1'b0}) - (A_W+1)'(h2r_pkg::UNIT_ONE);
    dl_abs = dl_nxt[A_W] ? A_W'(-dl_nxt) : A_W'(dl_nxt);
    a_full = (A_W+1)'(h2r_pkg::UNIT_ONE) - $signed({1'b0, dl_abs});
  end

  always_comb begin
    if (in_hue < HUE_W'(1 * h2r_pkg::SECTOR_UNITS)) begin
      sec_nxt = h2r_pkg::SEC_RED_YELLOW;
    end else if (in_hue < HUE_W'(2 * h2r_pkg::SECTOR_UNITS)) begin
      sec_nxt = h2r_pkg::SEC_YELLOW_GREEN;
    end else if (in_hue < HUE_W'(3 * h2r_pkg::SECTOR_UNITS)) begin
      sec_nxt = h2r_pkg::SEC_GREEN_CYAN;
    end else if (in_hue < HUE_W'(4 * h2r_pkg::SECTOR_UNITS)) begin
      sec_nxt = h2r_pkg::SEC_CYAN_BLUE;
    end else if (in_hue < HUE_W'(5 * h2r_pkg::SECTOR_UNITS)) begin
      sec_nxt = h2r_pkg::SEC_BLUE_MAGENTA;
    end else begin
      sec_nxt = h2r_pkg::SEC_MAGENTA_RED;
    end
  end

  always_comb begin
    wrap_nxt = '0;
    for (int k = 1; k <= h2r_pkg::HUE_WRAPS; k++) begin
      if (in_hue >= HUE_W'(k * h2r_pkg::HUE_PERIOD)) begin
        wrap_nxt = wrap_nxt + WRAP_W'(1);
      end
    end
  end

  logic [HUE_W-1:0]     s1_hue_r;
  logic [WRAP_W-1:0]    s1_wrap_r;
  logic [2:0]           s1_sec_r;
  logic signed [A_W-1:0] s1_a_r;
  logic [FRAC_W-1:0]    s1_sat_r;
  logic [FRAC_W-1:0]    s1_lig_r;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_hue_r  <= in_hue;
      s1_wrap_r <= wrap_nxt;
      s1_sec_r  <= sec_nxt;
      s1_a_r    <= a_full[A_W-1:0];
      s1_sat_r  <= in_sat;
      s1_lig_r  <= in_lig;
    end
  end

  // Stage 2: chroma = a * S, and the hue shape factor b = 1 - |h mod 2 - 1|.
  logic signed [AS_W-1:0] as_nxt;
  logic [HUE_W-1:0]       hm_full;
  logic signed [HM_W:0]   dh_nxt;
  logic [B_W-1:0]         dh_abs;
  logic [B_W-1:0]         b_nxt;

  always_comb begin
    as_nxt  = AS_W'(s1_a_r * $signed({1'b0, s1_sat_r}));
    hm_full = s1_hue_r - HUE_W'(s1_wrap_r) * HUE_W'(h2r_pkg::HUE_PERIOD);
    dh_nxt  = $signed({1'b0, hm_full[HM_W-1:0]}) - (HM_W+1)'(h2r_pkg::SECTOR_UNITS);
    dh_abs  = dh_nxt[HM_W] ? B_W'(-dh_nxt) : B_W'(dh_nxt);
    b_nxt   = B_W'(h2r_pkg::SECTOR_UNITS) - dh_abs;
  end

  logic signed [AS_W-1:0] s2_as_r;
  logic [B_W-1:0]         s2_b_r;
  logic [2:0]             s2_sec_r;
  logic [FRAC_W-1:0]      s2_lig_r;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_as_r  <= as_nxt;
      s2_b_r   <= b_nxt;
      s2_sec_r <= s1_sec_r;
      s2_lig_r <= s1_lig_r;
    end
  end

  // Stage 3: X term, C term and the lightness offset 2L - chroma.
  h2r_pkg::num_t          p_nxt;
  h2r_pkg::num_t          c_nxt;
  logic signed [D_W-1:0]  d_nxt;

  always_comb begin
    p_nxt = N_W'(s2_as_r * $signed({1'b0, s2_b_r}));
    c_nxt = (N_W'(s2_as_r) <<< 12) - (N_W'(s2_as_r) <<< 8);
    d_nxt = $signed({1'b0, s2_lig_r, 13'd0}) - D_W'(s2_as_r);
  end

  h2r_pkg::num_t         s3_p_r;
  h2r_pkg::num_t         s3_c_r;
  logic signed [D_W-1:0] s3_d_r;
  logic [2:0]            s3_sec_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_p_r   <= p_nxt;
      s3_c_r   <= c_nxt;
      s3_d_r   <= d_nxt;
      s3_sec_r <= s2_sec_r;
    end
  end

  // Stage 4: common offset m = 1920 * d, and the sector picks C, X or 0 per channel.
  h2r_pkg::num_t m_nxt;
  h2r_pkg::num_t k_nxt [3];

  always_comb begin
    m_nxt = (N_W'(s3_d_r) <<< 11) - (N_W'(s3_d_r) <<< 7);
    case (s3_sec_r)
      h2r_pkg::SEC_RED_YELLOW: begin
        k_nxt[0] = s3_c_r; k_nxt[1] = s3_p_r; k_nxt[2] = '0;
      end
      h2r_pkg::SEC_YELLOW_GREEN: begin
        k_nxt[0] = s3_p_r; k_nxt[1] = s3_c_r; k_nxt[2] = '0;
      end
      h2r_pkg::SEC_GREEN_CYAN: begin
        k_nxt[0] = '0;     k_nxt[1] = s3_c_r; k_nxt[2] = s3_p_r;
      end
      h2r_pkg::SEC_CYAN_BLUE: begin
        k_nxt[0] = '0;     k_nxt[1] = s3_p_r; k_nxt[2] = s3_c_r;
      end
      h2r_pkg::SEC_BLUE_MAGENTA: begin
        k_nxt[0] = s3_p_r; k_nxt[1] = '0;     k_nxt[2] = s3_c_r;
      end
      default: begin
        k_nxt[0] = s3_c_r; k_nxt[1] = '0;     k_nxt[2] = s3_p_r;
      end
    endcase
  end

  h2r_pkg::num_t s4_m_r;
  h2r_pkg::num_t s4_k_r [3];

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_m_r <= m_nxt;
      for (int c = 0; c < 3; c++) begin
        s4_k_r[c] <= k_nxt[c];
      end
    end
  end

  // Stage 5: channel numerators.
  h2r_pkg::num_t s5_n_r [3];

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      for (int c = 0; c < 3; c++) begin
        s5_n_r[c] <= s4_m_r + s4_k_r[c];
      end
    end
  end

  // Stage 6: scale by 255 and add the half-up rounding bias.
  h2r_pkg::tnum_t s6_t_r [3];

  always_ff @(posedge clk) begin
    if (s6_rdy) begin
      for (int c = 0; c < 3; c++) begin
        s6_t_r[c] <= (T_W'(s5_n_r[c]) <<< 8) - T_W'(s5_n_r[c])
                     + T_W'(h2r_pkg::ROUND_BIAS);
      end
    end
  end

  // Stage 7: divide by 15 * 2^32 with a reciprocal, clamp below 0 and above 255.
  logic [U_W-1:0]      u_val  [3];
  logic [2*UQ_W+1:0]   q_prod [3];
  logic [CH_W-1:0]     ch_nxt [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_val[c]  = s6_t_r[c][T_W-2:h2r_pkg::Q_SHIFT];
      q_prod[c] = (2*UQ_W+2)'({1'b0, u_val[c][UQ_W-1:0]} + (UQ_W+1)'(1))
                  * (2*UQ_W+2)'(h2r_pkg::RECIP_15);
      if (s6_t_r[c][T_W-1]) begin
        ch_nxt[c] = '0;
      end else if (u_val[c] >= U_W'(h2r_pkg::SAT_LIMIT)) begin
        ch_nxt[c] = '1;
      end else begin
        ch_nxt[c] = q_prod[c][16+CH_W-1:16];
      end
    end
  end

  logic [CH_W-1:0] out_ch_r [3];

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      for (int c = 0; c < 3; c++) begin
        out_ch_r[c] <= ch_nxt[c];
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_ch_r[2], out_ch_r[1], out_ch_r[0]};

  // With the result side ready, the whole pipeline moves and takes an item.
  a_ready_passes : assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled although the output side is ready");

  // The input only stalls when every stage is full and the result is held.
  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && s5_v_r && s6_v_r
                    && out_v_r && !out_tready))
    else $error("input stalled with an empty stage in the pipeline");

  // An item leaving the last stage becomes the shown result.
  a_last_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (s6_v_r && out_rdy) |=> out_tvalid)
    else $error("item lost between the last stage and the output");

  // A negative scaled red value clamps red to zero.
  a_red_clamps_low : assert property (@(posedge clk) disable iff (!rst_n)
    (s6_v_r && out_rdy && s6_t_r[0][T_W-1]) |=> (out_tdata[CH_W-1:0] == '0))
    else $error("negative red value not clamped to zero");

endmodule

// File: dv/hsl_to_rgb_converter_test.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

  localparam int HUE_W        = h2r_pkg::HUE_W;
  localparam int FRAC_W       = h2r_pkg::FRAC_W;
  localparam int CH_W         = h2r_pkg::CH_W;
  localparam int UNIT_ONE     = h2r_pkg::UNIT_ONE;
  localparam int SECTOR_UNITS = h2r_pkg::SECTOR_UNITS;

  // Pacing styles that each side of the stream switches between.
  localparam int PACE_STEADY = 0;
  localparam int PACE_BUSY   = 1;
  localparam int PACE_SPARSE = 2;

  localparam int MAX_IDLE     = 17;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] lig;
  } hsl_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  hsl_t pending_colours[$];
  rgb_t expected_rgb[$];
  int   mismatch_count = 0;
  int   accepted_items = 0;
  int   send_wait = 0;
  int   send_mode = PACE_STEADY;
  int   recv_wait = 0;
  int   recv_mode = PACE_STEADY;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  hsl_to_rgb_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale a channel numerator over the common denominator to 0..255, half up.
  function automatic logic [CH_W-1:0] channel_level(longint num, longint den);
    longint t;
    longint q;
    t = 510 * num + den;
    if (t < 0) return '0;
    q = t / (2 * den);
    if (q > 255) q = 255;
    return q[CH_W-1:0];
  endfunction

  // Exact integer HSL to RGB over the denominator 2 * 4096 * 4096 * 3840.
  function automatic rgb_t rgb_of(logic [HUE_W-1:0] hue_in, logic [FRAC_W-1:0] sat_in,
                                  logic [FRAC_W-1:0] lig_in);
    longint hue, sat, lig, den, dl, a, chroma, hm, dh, b, cn, xn, mn, rn, gn, bn;
    longint sector;
    logic [2:0] sec;
    rgb_t res;
    hue = longint'(hue_in);
    sat = longint'(sat_in);
    lig = longint'(lig_in);
    den = longint'(2) * UNIT_ONE * UNIT_ONE * SECTOR_UNITS;
    dl = 2 * lig - UNIT_ONE;
    if (dl < 0) dl = -dl;
    a = UNIT_ONE - dl;
    chroma = a * sat;
    hm = hue % (2 * SECTOR_UNITS);
    dh = hm - SECTOR_UNITS;
    if (dh < 0) dh = -dh;
    b = SECTOR_UNITS - dh;
    cn = 2 * SECTOR_UNITS * chroma;
    xn = 2 * chroma * b;
    mn = longint'(2) * SECTOR_UNITS * UNIT_ONE * lig - SECTOR_UNITS * chroma;
    // Every hue from 300 degrees up, wrapped or not, falls into the last sector.
    sector = hue / SECTOR_UNITS;
    sec = (sector >= 5) ? h2r_pkg::SEC_MAGENTA_RED : sector[2:0];
    case (sec)
      h2r_pkg::SEC_RED_YELLOW: begin
        rn = cn; gn = xn; bn = 0;
      end
      h2r_pkg::SEC_YELLOW_GREEN: begin
        rn = xn; gn = cn; bn = 0;
      end
      h2r_pkg::SEC_GREEN_CYAN: begin
        rn = 0; gn = cn; bn = xn;
      end
      h2r_pkg::SEC_CYAN_BLUE: begin
        rn = 0; gn = xn; bn = cn;
      end
      h2r_pkg::SEC_BLUE_MAGENTA: begin
        rn = xn; gn = 0; bn = cn;
      end
      default: begin
        rn = cn; gn = 0; bn = xn;
      end
    endcase
    res.red   = channel_level(rn + mn, den);
    res.green = channel_level(gn + mn, den);
    res.blue  = channel_level(bn + mn, den);
    return res;
  endfunction

  function automatic int idle_cycles(int mode);
    case (mode)
      PACE_STEADY: return 0;
      PACE_BUSY:   return int'($urandom_range(0, MAX_IDLE));
      default:     return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endcase
  endfunction

  task automatic queue_colour(int hue, int sat, int lig);
    hsl_t c;
    c.hue = HUE_W'(hue);
    c.sat = FRAC_W'(sat);
    c.lig = FRAC_W'(lig);
    pending_colours.push_back(c);
  endtask

  task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Draw a fraction: mostly in the legal range, sometimes anywhere in 13 bits.
  function automatic int random_fraction();
    case ($urandom_range(0, 9))
      0:       return int'($urandom_range(0, 8191));
      1:       return ($urandom_range(0, 1) == 0) ? 0 : UNIT_ONE;
      2:       return int'($urandom_range(4000, 4096));
      default: return int'($urandom_range(0, UNIT_ONE));
    endcase
  endfunction

  // Sender: offers the queued items, with a drawn gap after each one.
  always @(posedge clk) begin
    hsl_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rgb.push_back(rgb_of(in_tdata[15:0], in_tdata[28:16], in_tdata[41:29]));
        accepted_items <= accepted_items + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          in_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_colours.size() != 0) begin
          nxt = pending_colours.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, nxt.lig, nxt.sat, nxt.hue};
          if ($urandom_range(0, 63) == 0)
            send_mode <= int'($urandom_range(PACE_STEADY, PACE_SPARSE));
          send_wait <= idle_cycles(send_mode);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, so that the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result against the oldest expectation, then stalls a while.
  always @(posedge clk) begin
    int w;
    rgb_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
    end else begin
      w = recv_wait;
      if (out_tvalid && out_tready) begin
        if (expected_rgb.size() == 0) begin
          $error("result arrived with no expectation waiting: 0x%06h", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_rgb.pop_front();
          check_field("red", want.red, out_tdata[7:0]);
          check_field("green", want.green, out_tdata[15:8]);
          check_field("blue", want.blue, out_tdata[23:16]);
        end
        if ($urandom_range(0, 63) == 0)
          recv_mode <= int'($urandom_range(PACE_STEADY, PACE_SPARSE));
        w = idle_cycles(recv_mode);
      end else if (w > 0) begin
        w = w - 1;
      end
      recv_wait  <= w;
      out_tready <= (w == 0) && (hold_left == 0);
    end
  end

  initial begin
    int h;
    // Sector edges, the wrap at 360 degrees and the top of the hue range.
    queue_colour(0, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(3839, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(3840, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(7679, 3000, 1500);
    queue_colour(7680, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(11520, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(15360, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(19199, UNIT_ONE, 3000);
    queue_colour(19200, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(23039, 2500, 2500);
    queue_colour(23040, UNIT_ONE, UNIT_ONE / 2);
    queue_colour(65535, 8191, 8191);
    queue_colour(40000, UNIT_ONE, 1000);
    // Grey levels; lightness one half gives an exact tie that must round up.
    queue_colour(0, 0, 0);
    queue_colour(0, 0, UNIT_ONE / 2);
    queue_colour(0, 0, UNIT_ONE);
    queue_colour(1234, 0, 1);
    // Inputs above one drive channels below zero and above full scale; then black and white.
    queue_colour(0, 8191, 1000);
    queue_colour(5000, 8191, 3500);
    queue_colour(30000, 0, 8191);
    queue_colour(12000, 8191, 8191);
    queue_colour(65535, 8191, 0);
    queue_colour(17000, UNIT_ONE, 0);
    queue_colour(2000, UNIT_ONE, UNIT_ONE);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 3))
        0:       h = int'($urandom_range(0, 65535));
        1:       h = int'($urandom_range(0, 1) * SECTOR_UNITS * $urandom_range(0, 17)
                      + $urandom_range(0, 2));
        default: h = int'($urandom_range(0, 6 * SECTOR_UNITS - 1));
      endcase
      queue_colour(h, random_fraction(), random_fraction());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_colours.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_rgb.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/h2r_pkg.sv
rtl/core/hsl_to_rgb_converter.sv
dv/hsl_to_rgb_converter_test.sv
